// File: design/cie_pkg.sv
package cie_pkg;

  // Default size of the byte data memory. It must be a power of two.
  localparam int unsigned DATA_BYTES = 4096;

  localparam int unsigned XLEN = 32;
  localparam int unsigned NREGS = 16;
  localparam int unsigned NSREGS = 256;

  // Result codes carried on the exception port.
  localparam logic [2:0] EXC_NONE    = 3'd0;
  localparam logic [2:0] EXC_ILLEGAL = 3'd1;
  localparam logic [2:0] EXC_SWI     = 3'd2;
  localparam logic [2:0] EXC_BRK     = 3'd3;
  localparam logic [2:0] EXC_DIVZERO = 3'd4;

  // Bytes consumed by one word.
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_LONG  = 3'd6;

  // Special register that receives the immediate of a software interrupt.
  localparam logic [7:0] SREG_SWI = 8'd3;

endpackage

// File: design/compact_isa_execute_core_top.sv
// Execute core for a compact 32-bit instruction set. Each input word carries either one
// 16-bit instruction together with the 32-bit word that follows it in program memory, or
// a command that loads the program counter from that 32-bit word; each produces exactly
// one result word with the new pc, the bytes consumed, an exception code, a taken flag
// and the primary register write. The general registers, the 256 special registers and
// the byte data memory live in synchronous RAMs with registered reads, so the core works
// on one word at a time. After reset the data memory is swept to zero, one byte per
// cycle, and no word is accepted until the sweep ends. A set-pc command goes from
// acceptance straight to its result in S_FIN. An instruction reads its three register
// operands from the register RAM in S_RA, S_RB and S_RC, executes in S_EX, writes any
// register result in S_WB and presents its result in S_FIN. Each data memory access
// moves one byte per cycle through the single byte port; calls and returns make two
// word transfers. Divide and modulo run a restoring divider at one quotient bit per
// cycle. A finished result is held in an output register, and the next word is
// accepted while it waits to be taken. The DataBytes parameter must be a power of
// two; every byte address wraps modulo it.
module compact_isa_execute_core_top #(
  parameter int unsigned DataBytes = cie_pkg::DATA_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] instruction_i,
  input  logic [31:0] immediate_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [2:0]  instr_length_o,
  output logic [2:0]  exception_o,
  output logic        branch_taken_o,
  output logic        reg_write_valid_o,
  output logic [3:0]  reg_write_index_o,
  output logic [31:0] reg_write_value_o
);

  localparam int unsigned AW = $clog2(DataBytes);

  // Form 1 opcodes (upper byte of the instruction).
  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_LDI_L = 8'h01;
  localparam logic [7:0] OP_MOV   = 8'h02;
  localparam logic [7:0] OP_JSRA  = 8'h03;
  localparam logic [7:0] OP_RET   = 8'h04;
  localparam logic [7:0] OP_ADD   = 8'h05;
  localparam logic [7:0] OP_PUSH  = 8'h06;
  localparam logic [7:0] OP_POP   = 8'h07;
  localparam logic [7:0] OP_LDA_L = 8'h08;
  localparam logic [7:0] OP_STA_L = 8'h09;
  localparam logic [7:0] OP_LD_L  = 8'h0a;
  localparam logic [7:0] OP_ST_L  = 8'h0b;
  localparam logic [7:0] OP_LDO_L = 8'h0c;
  localparam logic [7:0] OP_STO_L = 8'h0d;
  localparam logic [7:0] OP_CMP   = 8'h0e;
  localparam logic [7:0] OP_JSR   = 8'h19;
  localparam logic [7:0] OP_JMPA  = 8'h1a;
  localparam logic [7:0] OP_LDI_B = 8'h1b;
  localparam logic [7:0] OP_LD_B  = 8'h1c;
  localparam logic [7:0] OP_LDA_B = 8'h1d;
  localparam logic [7:0] OP_ST_B  = 8'h1e;
  localparam logic [7:0] OP_STA_B = 8'h1f;
  localparam logic [7:0] OP_LDI_S = 8'h20;
  localparam logic [7:0] OP_LD_S  = 8'h21;
  localparam logic [7:0] OP_LDA_S = 8'h22;
  localparam logic [7:0] OP_ST_S  = 8'h23;
  localparam logic [7:0] OP_STA_S = 8'h24;
  localparam logic [7:0] OP_JMP   = 8'h25;
  localparam logic [7:0] OP_AND   = 8'h26;
  localparam logic [7:0] OP_LSHR  = 8'h27;
  localparam logic [7:0] OP_ASHL  = 8'h28;
  localparam logic [7:0] OP_SUB   = 8'h29;
  localparam logic [7:0] OP_NEG   = 8'h2a;
  localparam logic [7:0] OP_OR    = 8'h2b;
  localparam logic [7:0] OP_NOT   = 8'h2c;
  localparam logic [7:0] OP_ASHR  = 8'h2d;
  localparam logic [7:0] OP_XOR   = 8'h2e;
  localparam logic [7:0] OP_MUL   = 8'h2f;
  localparam logic [7:0] OP_SWI   = 8'h30;
  localparam logic [7:0] OP_DIV   = 8'h31;
  localparam logic [7:0] OP_UDIV  = 8'h32;
  localparam logic [7:0] OP_MOD   = 8'h33;
  localparam logic [7:0] OP_UMOD  = 8'h34;
  localparam logic [7:0] OP_BRK   = 8'h35;
  localparam logic [7:0] OP_LDO_B = 8'h36;
  localparam logic [7:0] OP_STO_B = 8'h37;
  localparam logic [7:0] OP_LDO_S = 8'h38;
  localparam logic [7:0] OP_STO_S = 8'h39;

  // Form 2 sub-operations.
  localparam logic [1:0] F2_INC = 2'd0;
  localparam logic [1:0] F2_DEC = 2'd1;
  localparam logic [1:0] F2_GSR = 2'd2;
  localparam logic [1:0] F2_SSR = 2'd3;

  localparam logic [3:0] REG_FP = 4'd0;
  localparam logic [3:0] REG_SP = 4'd1;
  localparam logic [3:0] LAST_COND = 4'd9;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RA, S_RB, S_RC, S_EX, S_SRD, S_MEM, S_DIV, S_POST, S_AUX, S_WB, S_FIN
  } state_e;

  typedef struct packed {
    logic        go;
    logic [31:0] addr;
    logic [2:0]  n;
    logic        wr;
    logic [31:0] wd;
  } mem_req_t;

  function automatic logic cond_met(logic [3:0] c, logic [31:0] a, logic [31:0] b);
    logic [31:0] sa;
    logic [31:0] sb;
    logic        r;
    sa = a ^ 32'h8000_0000;
    sb = b ^ 32'h8000_0000;
    case (c)
      4'd0:    r = (a == b);
      4'd1:    r = (a != b);
      4'd2:    r = (sa < sb);
      4'd3:    r = (sa > sb);
      4'd4:    r = (a < b);
      4'd5:    r = (a > b);
      4'd6:    r = (sa >= sb);
      4'd7:    r = (sa <= sb);
      4'd8:    r = (a >= b);
      default: r = (a <= b);
    endcase
    return r;
  endfunction

  state_e      state_q;
  logic [15:0] op_q;
  logic [31:0] imm_q;
  logic [31:0] pc_q;
  logic [31:0] cmp_l_q, cmp_r_q;
  logic [31:0] va_q, vb_q, vc_q;
  logic [15:0] rf_vld_q;
  logic [255:0] sr_vld_q;
  logic [3:0]  rf_ra_q;
  logic [7:0]  sr_ra_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] mem_addr_q;
  logic [2:0]  mem_i_q, mem_n_q;
  logic        mem_wr_q;
  logic [31:0] mem_wd_q;
  logic [31:0] acc_q;
  logic        phase_q;
  logic        aux_en_q;
  logic [3:0]  aux_idx_q;
  logic [31:0] aux_val_q;
  logic [31:0] w_npc_q, w_val_q;
  logic [2:0]  w_len_q, w_exc_q;
  logic        w_tk_q, w_wv_q;
  logic [3:0]  w_wi_q;
  logic [31:0] dq_q, dr_q, dd_q;
  logic [4:0]  dcnt_q;
  logic        dneg_q, drem_q;
  logic        out_valid_q;
  logic [31:0] o_npc_q, o_val_q;
  logic [2:0]  o_len_q, o_exc_q;
  logic        o_tk_q, o_wv_q;
  logic [3:0]  o_wi_q;

  logic [7:0]  opc;
  logic [3:0]  fa, fb;
  logic        is_f1, is_f2, is_f3, callret;
  logic [3:0]  idx_a, idx_b;

  assign opc   = op_q[15:8];
  assign fa    = op_q[7:4];
  assign fb    = op_q[3:0];
  assign is_f1 = ~op_q[15];
  assign is_f2 = op_q[15] & ~op_q[14];
  assign is_f3 = op_q[15] & op_q[14];
  assign callret = is_f1 & (opc == OP_JSRA || opc == OP_JSR || opc == OP_RET);
  // Calls and returns read fp and sp first; a jsr also needs its target register.
  assign idx_a = is_f2 ? op_q[11:8] : (callret ? REG_FP : fa);
  assign idx_b = callret ? REG_SP : fb;

  // Register file RAM.
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [31:0] rf_wdata, rf_rdata, rf_val;

  always_comb begin
    case (state_q)
      S_RA:    rf_raddr = idx_a;
      S_RB:    rf_raddr = idx_b;
      default: rf_raddr = fa;
    endcase
    rf_we    = 1'b0;
    rf_waddr = w_wi_q;
    rf_wdata = w_val_q;
    if (state_q == S_AUX) begin
      rf_we    = aux_en_q;
      rf_waddr = aux_idx_q;
      rf_wdata = aux_val_q;
    end else if (state_q == S_WB) begin
      rf_we = w_wv_q;
    end
  end

  cie_ram #(.Width(cie_pkg::XLEN), .Depth(cie_pkg::NREGS)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  // Entries never written since reset read as zero.
  assign rf_val = rf_vld_q[rf_ra_q] ? rf_rdata : '0;

  // Special register RAM.
  logic        sr_we;
  logic [7:0]  sr_waddr, sr_raddr;
  logic [31:0] sr_wdata, sr_rdata, sr_val;

  assign sr_raddr = op_q[7:0];
  assign sr_we    = (state_q == S_EX) &&
                    ((is_f2 && op_q[13:12] == F2_SSR) || (is_f1 && opc == OP_SWI));
  assign sr_waddr = is_f2 ? op_q[7:0] : cie_pkg::SREG_SWI;
  assign sr_wdata = is_f2 ? va_q : imm_q;

  cie_ram #(.Width(cie_pkg::XLEN), .Depth(cie_pkg::NSREGS)) u_sr (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

  assign sr_val = sr_vld_q[sr_ra_q] ? sr_rdata : '0;

  // Byte data memory: swept to zero after reset, then one byte per cycle.
  logic          dm_we;
  logic [AW-1:0] dm_addr;
  logic [7:0]    dm_wdata, dm_rdata;

  always_comb begin
    if (state_q == S_CLR) begin
      dm_we    = 1'b1;
      dm_addr  = clr_q;
      dm_wdata = '0;
    end else begin
      dm_we    = (state_q == S_MEM) && mem_wr_q && (mem_i_q != mem_n_q);
      dm_addr  = mem_addr_q + AW'(mem_i_q);
      dm_wdata = mem_wd_q[31:24];
    end
  end

  cie_ram #(.Width(8), .Depth(DataBytes)) u_dm (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_addr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_addr),
    .rdata_o (dm_rdata)
  );

  // First memory transfer of an instruction, decoded from its operands.
  mem_req_t mreq;

  always_comb begin
    mreq = '0;
    if (is_f1) begin
      case (opc)
        OP_JSRA, OP_JSR: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd4; mreq.addr = vb_q - 32'd8;
          mreq.wd = (opc == OP_JSRA) ? pc_q + 32'd6 : pc_q + 32'd2;
        end
        OP_RET:   begin mreq.go = 1'b1; mreq.n = 3'd4; mreq.addr = va_q; end
        OP_PUSH: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd4; mreq.addr = va_q - 32'd4;
          mreq.wd = (fa == fb) ? va_q - 32'd4 : vb_q;
        end
        OP_POP:   begin mreq.go = 1'b1; mreq.n = 3'd4; mreq.addr = va_q; end
        OP_LDA_L: begin mreq.go = 1'b1; mreq.n = 3'd4; mreq.addr = imm_q; end
        OP_LDA_B: begin mreq.go = 1'b1; mreq.n = 3'd1; mreq.addr = imm_q; end
        OP_LDA_S: begin mreq.go = 1'b1; mreq.n = 3'd2; mreq.addr = imm_q; end
        OP_LD_L:  begin mreq.go = 1'b1; mreq.n = 3'd4; mreq.addr = vb_q; end
        OP_LD_B:  begin mreq.go = 1'b1; mreq.n = 3'd1; mreq.addr = vb_q; end
        OP_LD_S:  begin mreq.go = 1'b1; mreq.n = 3'd2; mreq.addr = vb_q; end
        OP_LDO_L: begin mreq.go = 1'b1; mreq.n = 3'd4; mreq.addr = vb_q + imm_q; end
        OP_LDO_B: begin mreq.go = 1'b1; mreq.n = 3'd1; mreq.addr = vb_q + imm_q; end
        OP_LDO_S: begin mreq.go = 1'b1; mreq.n = 3'd2; mreq.addr = vb_q + imm_q; end
        OP_STA_L: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd4; mreq.addr = imm_q; mreq.wd = va_q;
        end
        OP_STA_B: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd1; mreq.addr = imm_q; mreq.wd = va_q;
        end
        OP_STA_S: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd2; mreq.addr = imm_q; mreq.wd = va_q;
        end
        OP_ST_L: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd4; mreq.addr = va_q; mreq.wd = vb_q;
        end
        OP_ST_B: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd1; mreq.addr = va_q; mreq.wd = vb_q;
        end
        OP_ST_S: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd2; mreq.addr = va_q; mreq.wd = vb_q;
        end
        OP_STO_L: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd4; mreq.addr = va_q + imm_q;
          mreq.wd = vb_q;
        end
        OP_STO_B: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd1; mreq.addr = va_q + imm_q;
          mreq.wd = vb_q;
        end
        OP_STO_S: begin
          mreq.go = 1'b1; mreq.wr = 1'b1; mreq.n = 3'd2; mreq.addr = va_q + imm_q;
          mreq.wd = vb_q;
        end
        default: mreq.go = 1'b0;
      endcase
      // Stores shift out most significant byte first, so left-align the data.
      case (mreq.n)
        3'd1:    mreq.wd = {mreq.wd[7:0], 24'h0};
        3'd2:    mreq.wd = {mreq.wd[15:0], 16'h0};
        default: mreq.wd = mreq.wd;
      endcase
    end
  end

  // One restoring divide step.
  logic [32:0] div_sh, div_diff;
  assign div_sh   = {dr_q, dq_q[31]};
  assign div_diff = div_sh - {1'b0, dd_q};

  logic [31:0] div_res;
  assign div_res = drem_q ? dr_q : dq_q;

  logic        dv_signed, dv_na, dv_nb;
  assign dv_signed = (opc == OP_DIV) || (opc == OP_MOD);
  assign dv_na     = dv_signed & va_q[31];
  assign dv_nb     = dv_signed & vb_q[31];

  logic [31:0] mul_lo, ashr_res;
  assign mul_lo   = va_q * vb_q;
  assign ashr_res = $unsigned($signed(va_q) >>> vb_q[4:0]);

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      pc_q        <= '0;
      cmp_l_q     <= '0;
      cmp_r_q     <= '0;
      rf_vld_q    <= '0;
      sr_vld_q    <= '0;
      rf_ra_q     <= '0;
      sr_ra_q     <= '0;
      out_valid_q <= 1'b0;
      op_q <= '0; imm_q <= '0; va_q <= '0; vb_q <= '0; vc_q <= '0;
      mem_addr_q <= '0; mem_i_q <= '0; mem_n_q <= '0; mem_wr_q <= 1'b0; mem_wd_q <= '0;
      acc_q <= '0; phase_q <= 1'b0;
      aux_en_q <= 1'b0; aux_idx_q <= '0; aux_val_q <= '0;
      w_npc_q <= '0; w_len_q <= '0; w_exc_q <= '0; w_tk_q <= 1'b0;
      w_wv_q <= 1'b0; w_wi_q <= '0; w_val_q <= '0;
      dq_q <= '0; dr_q <= '0; dd_q <= '0; dcnt_q <= '0; dneg_q <= 1'b0; drem_q <= 1'b0;
      o_npc_q <= '0; o_len_q <= '0; o_exc_q <= '0; o_tk_q <= 1'b0;
      o_wv_q <= 1'b0; o_wi_q <= '0; o_val_q <= '0;
    end else begin
      rf_ra_q <= rf_raddr;
      sr_ra_q <= sr_raddr;
      if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
      if (sr_we) sr_vld_q[sr_waddr] <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DataBytes - 1)) state_q <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= instruction_i;
            imm_q <= immediate_word_i;
            if (command_i) begin
              w_npc_q <= immediate_word_i;
              w_len_q <= cie_pkg::LEN_NONE;
              w_exc_q <= cie_pkg::EXC_NONE;
              w_tk_q  <= 1'b1;
              w_wv_q  <= 1'b0;
              w_wi_q  <= '0;
              w_val_q <= '0;
              state_q <= S_FIN;
            end else begin
              state_q <= S_RA;
            end
          end
        end

        S_RA: state_q <= S_RB;
        S_RB: begin va_q <= rf_val; state_q <= S_RC; end
        S_RC: begin vb_q <= rf_val; state_q <= S_EX; end

        S_EX: begin
          vc_q     <= rf_val;
          w_npc_q  <= pc_q + 32'd2;
          w_len_q  <= cie_pkg::LEN_SHORT;
          w_exc_q  <= cie_pkg::EXC_NONE;
          w_tk_q   <= 1'b0;
          w_wv_q   <= 1'b0;
          w_wi_q   <= '0;
          w_val_q  <= '0;
          aux_en_q <= 1'b0;
          phase_q  <= 1'b0;
          acc_q    <= '0;
          mem_i_q  <= '0;
          mem_addr_q <= mreq.addr[AW-1:0];
          mem_n_q  <= mreq.n;
          mem_wr_q <= mreq.wr;
          mem_wd_q <= mreq.wd;
          state_q  <= S_WB;
          if (is_f3) begin
            if (op_q[13:10] > LAST_COND) begin
              w_exc_q <= cie_pkg::EXC_ILLEGAL;
            end else if (cond_met(op_q[13:10], cmp_l_q, cmp_r_q)) begin
              w_npc_q <= pc_q + 32'd2 + {{21{op_q[9]}}, op_q[9:0], 1'b0};
              w_tk_q  <= 1'b1;
            end
            state_q <= S_FIN;
          end else if (is_f2) begin
            w_wi_q <= op_q[11:8];
            case (op_q[13:12])
              F2_INC: begin w_wv_q <= 1'b1; w_val_q <= va_q + {24'h0, op_q[7:0]}; end
              F2_DEC: begin w_wv_q <= 1'b1; w_val_q <= va_q - {24'h0, op_q[7:0]}; end
              F2_GSR: begin w_wv_q <= 1'b1; state_q <= S_SRD; end
              default: state_q <= S_FIN;
            endcase
          end else begin
            case (opc)
              OP_NOP: ;
              OP_LDI_L, OP_LDI_B, OP_LDI_S: begin
                w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= imm_q;
                w_len_q <= cie_pkg::LEN_LONG; w_npc_q <= pc_q + 32'd6;
              end
              OP_MOV: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= vb_q; end
              OP_JSRA: begin
                w_len_q <= cie_pkg::LEN_LONG; w_tk_q <= 1'b1; w_npc_q <= imm_q;
                w_wv_q <= 1'b1; w_wi_q <= REG_FP;
              end
              OP_JSR: begin
                // The target is read after the frame is built: fp and sp both hold sp-12.
                w_tk_q <= 1'b1; w_wv_q <= 1'b1; w_wi_q <= REG_FP;
                w_npc_q <= (fa == REG_FP || fa == REG_SP) ? vb_q - 32'd12 : rf_val;
              end
              OP_RET: begin w_tk_q <= 1'b1; w_wv_q <= 1'b1; w_wi_q <= REG_FP; end
              OP_ADD: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q + vb_q; end
              OP_PUSH: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q - 32'd4; end
              OP_POP: begin w_wv_q <= 1'b1; w_wi_q <= fb; end
              OP_LDA_L, OP_LDA_B, OP_LDA_S, OP_LDO_L, OP_LDO_B, OP_LDO_S: begin
                w_wv_q <= 1'b1; w_wi_q <= fa;
                w_len_q <= cie_pkg::LEN_LONG; w_npc_q <= pc_q + 32'd6;
              end
              OP_STA_L, OP_STA_B, OP_STA_S, OP_STO_L, OP_STO_B, OP_STO_S: begin
                w_len_q <= cie_pkg::LEN_LONG; w_npc_q <= pc_q + 32'd6;
              end
              OP_LD_L, OP_LD_B, OP_LD_S: begin w_wv_q <= 1'b1; w_wi_q <= fa; end
              OP_ST_L, OP_ST_B, OP_ST_S: ;
              OP_CMP: begin cmp_l_q <= va_q; cmp_r_q <= vb_q; end
              OP_JMPA: begin
                w_len_q <= cie_pkg::LEN_LONG; w_tk_q <= 1'b1; w_npc_q <= imm_q;
              end
              OP_JMP:  begin w_tk_q <= 1'b1; w_npc_q <= va_q; end
              OP_AND:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q & vb_q; end
              OP_LSHR: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q >> vb_q[4:0]; end
              OP_ASHL: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q << vb_q[4:0]; end
              OP_SUB:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q - vb_q; end
              OP_NEG:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= 32'd0 - vb_q; end
              OP_OR:   begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q | vb_q; end
              OP_NOT:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= ~vb_q; end
              OP_ASHR: begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= ashr_res; end
              OP_XOR:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= va_q ^ vb_q; end
              OP_MUL:  begin w_wv_q <= 1'b1; w_wi_q <= fa; w_val_q <= mul_lo; end
              OP_SWI:  begin w_exc_q <= cie_pkg::EXC_SWI; state_q <= S_FIN; end
              OP_DIV, OP_UDIV, OP_MOD, OP_UMOD: begin
                if (vb_q == '0) begin
                  w_exc_q <= cie_pkg::EXC_DIVZERO;
                  state_q <= S_FIN;
                end else begin
                  w_wv_q <= 1'b1; w_wi_q <= fa;
                  dq_q   <= dv_na ? 32'd0 - va_q : va_q;
                  dd_q   <= dv_nb ? 32'd0 - vb_q : vb_q;
                  dr_q   <= '0;
                  dcnt_q <= '0;
                  drem_q <= (opc == OP_MOD) || (opc == OP_UMOD);
                  dneg_q <= ((opc == OP_MOD) || (opc == OP_UMOD)) ? dv_na : (dv_na ^ dv_nb);
                  state_q <= S_DIV;
                end
              end
              OP_BRK:  begin w_exc_q <= cie_pkg::EXC_BRK; state_q <= S_FIN; end
              default: begin w_exc_q <= cie_pkg::EXC_ILLEGAL; state_q <= S_FIN; end
            endcase
            if (mreq.go) state_q <= S_MEM;
          end
        end

        S_SRD: begin w_val_q <= sr_val; state_q <= S_WB; end

        S_MEM: begin
          // Read data comes from the registered RAM read behind its address and is shifted in big-endian.
          if (!mem_wr_q && mem_i_q != 3'd0) acc_q <= {acc_q[23:0], dm_rdata};
          if (mem_i_q == mem_n_q) begin
            state_q <= S_POST;
          end else begin
            mem_i_q <= mem_i_q + 3'd1;
            if (mem_wr_q) mem_wd_q <= {mem_wd_q[23:0], 8'h0};
          end
        end

        S_DIV: begin
          if (!div_diff[32]) dr_q <= div_diff[31:0];
          else dr_q <= div_sh[31:0];
          dq_q   <= {dq_q[30:0], ~div_diff[32]};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) state_q <= S_POST;
        end

        S_POST: begin
          state_q <= S_WB;
          case (opc)
            OP_JSRA, OP_JSR: begin
              if (!phase_q) begin
                // Second frame word: the old fp goes to sp-12.
                phase_q    <= 1'b1;
                mem_addr_q <= AW'(vb_q - 32'd12);
                mem_wd_q   <= va_q;
                mem_wr_q   <= 1'b1;
                mem_n_q    <= 3'd4;
                mem_i_q    <= '0;
                state_q    <= S_MEM;
              end else begin
                aux_en_q  <= 1'b1;
                aux_idx_q <= REG_SP;
                aux_val_q <= vb_q - 32'd12;
                w_val_q   <= vb_q - 32'd12;
                state_q   <= S_AUX;
              end
            end
            OP_RET: begin
              if (!phase_q) begin
                phase_q    <= 1'b1;
                vc_q       <= acc_q;
                acc_q      <= '0;
                mem_addr_q <= AW'(va_q + 32'd4);
                mem_i_q    <= '0;
                state_q    <= S_MEM;
              end else begin
                w_npc_q   <= acc_q;
                w_val_q   <= vc_q;
                aux_en_q  <= 1'b1;
                aux_idx_q <= REG_SP;
                aux_val_q <= va_q + 32'd12;
                state_q   <= S_AUX;
              end
            end
            OP_POP: begin
              // When both operands name one register, it ends as the loaded word plus 4.
              aux_en_q  <= (fa != fb);
              aux_idx_q <= fa;
              aux_val_q <= va_q + 32'd4;
              w_val_q   <= (fa == fb) ? acc_q + 32'd4 : acc_q;
              state_q   <= S_AUX;
            end
            OP_DIV, OP_UDIV, OP_MOD, OP_UMOD: w_val_q <= dneg_q ? 32'd0 - div_res : div_res;
            OP_PUSH: ;
            default: w_val_q <= acc_q;
          endcase
        end

        S_AUX: state_q <= S_WB;
        S_WB:  state_q <= S_FIN;

        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (w_exc_q != cie_pkg::EXC_NONE) begin
              o_npc_q <= pc_q;
              o_len_q <= cie_pkg::LEN_NONE;
              o_tk_q  <= 1'b0;
              o_wv_q  <= 1'b0;
            end else begin
              o_npc_q <= w_npc_q;
              o_len_q <= w_len_q;
              o_tk_q  <= w_tk_q;
              o_wv_q  <= w_wv_q;
              pc_q    <= w_npc_q;
            end
            o_exc_q <= w_exc_q;
            o_wi_q  <= (w_wv_q && w_exc_q == cie_pkg::EXC_NONE) ? w_wi_q : '0;
            o_val_q <= (w_wv_q && w_exc_q == cie_pkg::EXC_NONE) ? w_val_q : '0;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = o_npc_q;
  assign instr_length_o    = o_len_q;
  assign exception_o       = o_exc_q;
  assign branch_taken_o    = o_tk_q;
  assign reg_write_valid_o = o_wv_q;
  assign reg_write_index_o = o_wi_q;
  assign reg_write_value_o = o_val_q;

endmodule

// File: design/cie_ram.sv
module cie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
